// ===== hdl/sapq_pkg.sv =====
// Shared constants and types for the sorted-array minimum priority queue.
package sapq_pkg;

    localparam int DEPTH   = 16;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STAT_W  = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [CNT_W-1:0]        count_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } sapq_cmd_t;

endpackage

// ===== hdl/sapq_ctrl.sv =====
// Controller: sequences item capture, execution and result hand-off.
module sapq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output sapq_pkg::sapq_cmd_t cmd
);
    import sapq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/sapq_dp.sv =====
// Datapath: sorted entry cells with compare-and-shift, count and result registers.
module sapq_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sapq_pkg::sapq_cmd_t           cmd,
    input  logic                          in_opcode,
    input  sapq_pkg::value_t              in_value,
    output logic [sapq_pkg::STAT_W-1:0]   res_status,
    output sapq_pkg::value_t              res_removed_value,
    output sapq_pkg::value_t              res_front_value,
    output logic                          res_is_empty,
    output sapq_pkg::count_t              res_entry_count
);
    import sapq_pkg::*;

    logic   op_reg;
    value_t val_reg;
    value_t entries_reg [DEPTH];
    value_t entries_next[DEPTH];
    count_t cnt_reg, cnt_next;

    logic [STAT_W-1:0] status_reg, status_next;
    value_t removed_reg, removed_next;
    value_t front_reg, front_next;
    logic   empty_reg;
    count_t count_reg;

    logic full, empty;
    logic [DEPTH-1:0] gt;
    logic [DEPTH-1:0] place;

    assign full  = (cnt_reg == count_t'(DEPTH));
    assign empty = (cnt_reg == '0);

    // Each cell compares its own entry with the key; the greater ones form a suffix.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i]    = (count_t'(i) < cnt_reg) && (entries_reg[i] > val_reg);
            place[i] = gt[i] || (count_t'(i) == cnt_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) entries_next[i] = entries_reg[i];
        cnt_next     = cnt_reg;
        status_next  = STAT_OK;
        removed_next = '0;
        unique case (op_reg)
            OP_INSERT: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (place[i]) begin
                            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                                entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                            end else begin
                                entries_next[i] = val_reg;
                            end
                        end
                    end
                    cnt_next = cnt_reg + count_t'(1);
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    removed_next = entries_reg[0];
                    for (int i = 0; i < DEPTH - 1; i++) entries_next[i] = entries_reg[i + 1];
                    cnt_next = cnt_reg - count_t'(1);
                end
            end
            default: status_next = STAT_OK;
        endcase
        front_next = (cnt_next != '0) ? entries_next[0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= in_opcode;
            val_reg <= in_value;
        end
        if (cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) entries_reg[i] <= entries_next[i];
            status_reg  <= status_next;
            removed_reg <= removed_next;
            front_reg   <= front_next;
            empty_reg   <= (cnt_next == '0);
            count_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.exec) begin
            cnt_reg <= cnt_next;
        end
    end

    assign res_status        = status_reg;
    assign res_removed_value = removed_reg;
    assign res_front_value   = front_reg;
    assign res_is_empty      = empty_reg;
    assign res_entry_count   = count_reg;

endmodule

// ===== hdl/sorted_array_min_priority_queue.sv =====
// Top level of the sorted-array minimum priority queue.
//
//   channel | direction | transfer payload
//   s_      | in        | opcode, value
//   m_      | out       | status, removed_value, front_value, is_empty, entry_count
//
// Each item is captured, then executed as all entry cells compare and shift
// together. The next item is taken after that, even while its result waits.
// Reset (aresetn, synchronous) empties the queue; entries are not cleared.
// A stalled result holds execution of the captured item until m_ready.
module sorted_array_min_priority_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  sapq_pkg::value_t            s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sapq_pkg::STAT_W-1:0] m_status,
    output sapq_pkg::value_t            m_removed_value,
    output sapq_pkg::value_t            m_front_value,
    output logic                        m_is_empty,
    output sapq_pkg::count_t            m_entry_count
);
    import sapq_pkg::*;

    sapq_cmd_t cmd;

    sapq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    sapq_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_opcode         (s_opcode),
        .in_value          (s_value),
        .res_status        (m_status),
        .res_removed_value (m_removed_value),
        .res_front_value   (m_front_value),
        .res_is_empty      (m_is_empty),
        .res_entry_count   (m_entry_count)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the sorted-array minimum priority queue: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import sapq_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int RAND_ITEMS   = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        logic [STAT_W-1:0] status;
        value_t            removed;
        value_t            front;
        logic              empty;
        count_t            count;
    } result_t;

    typedef struct {
        logic    op;
        value_t  val;
        bit      typed;
        result_t res;
    } row_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_opcode;
    value_t            s_value;
    logic              m_valid;
    logic              m_ready;
    logic [STAT_W-1:0] m_status;
    value_t            m_removed_value;
    value_t            m_front_value;
    logic              m_is_empty;
    count_t            m_entry_count;

    value_t  model_entries [DEPTH];
    int      model_count;
    result_t pending_results [$];
    row_t    directed_rows [$];
    int      errors      = 0;
    int      stall_cycles = 0;
    bit      no_idle     = 1'b0;
    bit      hold_req    = 1'b0;
    bit      hold_done   = 1'b0;

    sorted_array_min_priority_queue DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_front_value   (m_front_value),
        .m_is_empty      (m_is_empty),
        .m_entry_count   (m_entry_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Sorted insert / remove-front on the model store; equal values go after held ones.
    function automatic result_t predict_queue_op(input logic op, input value_t v);
        result_t r;
        int      pos;
        r.status  = STAT_OK;
        r.removed = '0;
        if (op == OP_INSERT) begin
            if (model_count >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                pos = model_count;
                while (pos > 0 && model_entries[pos-1] > v) begin
                    model_entries[pos] = model_entries[pos-1];
                    pos--;
                end
                model_entries[pos] = v;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.removed = model_entries[0];
                for (int i = 1; i < model_count; i++)
                    model_entries[i-1] = model_entries[i];
                model_count--;
            end
        end
        r.front = (model_count > 0) ? model_entries[0] : '0;
        r.empty = (model_count == 0);
        r.count = count_t'(model_count);
        return r;
    endfunction

    function automatic result_t mk_res(input logic [STAT_W-1:0] st, input value_t rm,
                                       input value_t fr, input logic em, input count_t cn);
        result_t r;
        r.status  = st;
        r.removed = rm;
        r.front   = fr;
        r.empty   = em;
        r.count   = cn;
        return r;
    endfunction

    task automatic add_row(input logic op, input value_t v, input bit typed, input result_t res);
        row_t r;
        r.op    = op;
        r.val   = v;
        r.typed = typed;
        r.res   = res;
        directed_rows.push_back(r);
    endtask

    task automatic send_item(input logic op, input value_t v, input bit typed,
                             input result_t typed_res);
        result_t pred;
        if (!no_idle) begin
            while ($urandom_range(99) < 25) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= v;
        do @(posedge aclk); while (!s_ready);
        pred = predict_queue_op(op, v);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    initial begin
        value_t  vmax;
        value_t  vmin;
        value_t  fill_vals [16];
        result_t none;
        logic    op;
        value_t  v;
        int      ins_pct;
        int      mode;
        vmax = 32'sh7fff_ffff;
        vmin = 32'sh8000_0000;
        fill_vals = '{14, -1, -1, 0, 32'sh7fff_ffff, 32'sh8000_0000, 14, 100, -100, 5, 5,
                      32'sh7fff_fffe, 32'sh8000_0001, 3, -7, 1};
        none = mk_res(STAT_OK, 0, 0, 1'b0, '0);

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = OP_INSERT;
        s_value     = '0;
        model_count = 0;

        add_row(OP_REMOVE, 0,    1'b1, mk_res(STAT_EMPTY, 0, 0, 1'b1, '0));
        add_row(OP_INSERT, vmax, 1'b1, mk_res(STAT_OK, 0, vmax, 1'b0, count_t'(1)));
        add_row(OP_INSERT, vmin, 1'b1, mk_res(STAT_OK, 0, vmin, 1'b0, count_t'(2)));
        add_row(OP_REMOVE, 0,    1'b1, mk_res(STAT_OK, vmin, vmax, 1'b0, count_t'(1)));
        add_row(OP_REMOVE, -1,   1'b1, mk_res(STAT_OK, vmax, 0, 1'b1, '0));
        add_row(OP_REMOVE, vmax, 1'b1, mk_res(STAT_EMPTY, 0, 0, 1'b1, '0));
        foreach (fill_vals[i])
            add_row(OP_INSERT, fill_vals[i], 1'b0, none);
        add_row(OP_INSERT, -5, 1'b1, mk_res(STAT_FULL, 0, vmin, 1'b0, count_t'(DEPTH)));
        add_row(OP_REMOVE, 0,  1'b0, none);
        add_row(OP_INSERT, 7,  1'b0, none);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].typed,
                      directed_rows[i].res);

        ins_pct = 50;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            // insert bias changes every 50 items so the queue swings between full and empty
            if (n % 50 == 0) begin
                case ($urandom_range(4))
                    0: ins_pct = 90;
                    1: ins_pct = 10;
                    2: ins_pct = 70;
                    3: ins_pct = 30;
                    default: ins_pct = 50;
                endcase
            end
            if (n == 100) hold_req = 1'b1;
            no_idle = (n >= 300 && n < 500);
            op   = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
            mode = $urandom_range(99);
            if (mode < 60) begin
                v = $urandom;
            end else if (mode < 85) begin
                v = $signed($urandom_range(8)) - 4;
            end else begin
                case ($urandom_range(4))
                    0: v = vmax;
                    1: v = vmin;
                    2: v = 0;
                    3: v = -1;
                    default: v = 14;
                endcase
            end
            send_item(op, v, 1'b0, none);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off that fills the block.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready  <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 25);
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, status %0d", $time, m_status);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, m_status);
                        errors++;
                    end
                    if (m_removed_value !== want.removed) begin
                        $display("%0t: removed_value expected %0d, actual %0d",
                                 $time, want.removed, m_removed_value);
                        errors++;
                    end
                    if (m_front_value !== want.front) begin
                        $display("%0t: front_value expected %0d, actual %0d",
                                 $time, want.front, m_front_value);
                        errors++;
                    end
                    if (m_is_empty !== want.empty) begin
                        $display("%0t: is_empty expected %0d, actual %0d",
                                 $time, want.empty, m_is_empty);
                        errors++;
                    end
                    if (m_entry_count !== want.count) begin
                        $display("%0t: entry_count expected %0d, actual %0d",
                                 $time, want.count, m_entry_count);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: timeout, no transfer for %0d cycles", $time, stall_cycles);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
hdl/sapq_pkg.sv
hdl/sapq_ctrl.sv
hdl/sapq_dp.sv
hdl/sorted_array_min_priority_queue.sv
tb/sv/tb_top.sv
